@@ hdl/quaternion_to_euler_angles_core_assert.svh @@
// Assertion shorthands shared by the RTL.
`ifndef QUATERNION_TO_EULER_ANGLES_CORE_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define Q2E_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define Q2E_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/q2e_pkg.sv @@
package q2e_pkg;

	localparam int ANGLE_FRAC_BITS = 7;

	localparam int M_W          = 36;
	localparam int XW           = 44;
	localparam int ACC_W        = 26;
	localparam int NORM_BIT     = 40;
	localparam int CORDIC_STEPS = 20;
	localparam int CORDIC_LAT   = CORDIC_STEPS + 3;
	localparam int SQRT_STEPS   = 32;
	localparam int SQRT_W       = 64;
	localparam int MSB_W        = $clog2(M_W + NORM_BIT);
	localparam int DEG_UNIT     = 65536;

	typedef logic signed [M_W-1:0]   mval_t;
	typedef logic signed [ACC_W-1:0] angle_t;
	typedef logic signed [ACC_W:0]   wide_angle_t;
	typedef logic signed [31:0]      prod_t;

	typedef struct packed {
		mval_t m11;
		mval_t m12;
		mval_t m23;
		mval_t m33;
		mval_t asin_num;
	} pend_t;

	localparam angle_t DEG90  = ACC_W'(90 * DEG_UNIT);
	localparam angle_t DEG180 = ACC_W'(180 * DEG_UNIT);

	localparam wide_angle_t RND_HALF = (ACC_W + 1)'(1 << (15 - ANGLE_FRAC_BITS));
	localparam int          RND_SH   = 16 - ANGLE_FRAC_BITS;
	localparam wide_angle_t LIM180   = (ACC_W + 1)'(180 << ANGLE_FRAC_BITS);
	localparam wide_angle_t LIM90    = (ACC_W + 1)'(90 << ANGLE_FRAC_BITS);

	localparam angle_t ATAN_TAB [CORDIC_STEPS] = '{
		26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379,
		26'sd117304, 26'sd58666, 26'sd29335, 26'sd14668, 26'sd7334,
		26'sd3667, 26'sd1833, 26'sd917, 26'sd458, 26'sd229,
		26'sd115, 26'sd57, 26'sd29, 26'sd14, 26'sd7
	};

	// Rounds half up from 2^-16 degree to the output grid and clamps.
	function automatic wide_angle_t to_out(input wide_angle_t a, input wide_angle_t lim);
		wide_angle_t r;
		r = (a + RND_HALF) >>> RND_SH;
		if (r > lim) begin
			r = lim;
		end else if (r < -lim) begin
			r = -lim;
		end
		return r;
	endfunction

endpackage

@@ hdl/q2e_isqrt.sv @@
module q2e_isqrt (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic [q2e_pkg::SQRT_W-1:0]             rad,
	output logic [q2e_pkg::SQRT_W/2-1:0]           root
);
	import q2e_pkg::*;

	logic [SQRT_W-1:0] n_s [1:SQRT_STEPS];
	logic [SQRT_W-1:0] r_s [1:SQRT_STEPS];

	// One result bit per stage, trial bit walking down from the top pair.
	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_bit
		localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (SQRT_W - 2 - 2 * j);
		logic [SQRT_W-1:0] n_in, r_in;
		logic [SQRT_W-1:0] trial;
		if (j == 0) begin : g_head
			assign n_in = rad;
			assign r_in = '0;
		end else begin : g_body
			assign n_in = n_s[j];
			assign r_in = r_s[j];
		end
		assign trial = r_in + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (n_in >= trial) begin
					n_s[j+1] <= n_in - trial;
					r_s[j+1] <= (r_in >> 1) + BIT;
				end else begin
					n_s[j+1] <= n_in;
					r_s[j+1] <= r_in >> 1;
				end
			end
		end
	end

	assign root = r_s[SQRT_STEPS][SQRT_W/2-1:0];

endmodule

@@ hdl/q2e_cordic.sv @@
module q2e_cordic (
	input  logic            clk,
	input  logic            en,
	input  q2e_pkg::mval_t  y_in,
	input  q2e_pkg::mval_t  x_in,
	output q2e_pkg::angle_t angle
);
	import q2e_pkg::*;

	mval_t           xn, yn;
	logic [M_W-1:0]  ya, mxn;
	angle_t          bn;
	logic            spn;

	mval_t           x_s1, y_s1;
	logic [M_W-1:0]  mx_s1;
	angle_t          base_s1;
	logic            sp_s1;

	logic [MSB_W-1:0] msb, sh;

	logic signed [XW-1:0] x_s [0:CORDIC_STEPS];
	logic signed [XW-1:0] y_s [0:CORDIC_STEPS];
	angle_t               acc_s [0:CORDIC_STEPS];
	angle_t               base_s [0:CORDIC_STEPS];
	logic                 sp_s [0:CORDIC_STEPS];

	// Axis cases give a fixed answer; the left half plane is folded over.
	always_comb begin
		xn  = x_in;
		yn  = y_in;
		bn  = '0;
		spn = 1'b0;
		if (x_in == '0) begin
			spn = 1'b1;
			if (y_in == '0) begin
				bn = '0;
			end else if (y_in[M_W-1]) begin
				bn = -DEG90;
			end else begin
				bn = DEG90;
			end
		end else if (y_in == '0) begin
			spn = 1'b1;
			bn  = x_in[M_W-1] ? DEG180 : '0;
		end else if (x_in[M_W-1]) begin
			bn = y_in[M_W-1] ? -DEG180 : DEG180;
			xn = -x_in;
			yn = -y_in;
		end
		ya  = yn[M_W-1] ? $unsigned(-yn) : $unsigned(yn);
		mxn = ($unsigned(xn) > ya) ? $unsigned(xn) : ya;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= xn;
			y_s1    <= yn;
			mx_s1   <= mxn;
			base_s1 <= bn;
			sp_s1   <= spn;
		end
	end

	// Scale so that the larger magnitude lands on the normalizing bit.
	always_comb begin
		msb = '0;
		for (int i = 0; i < M_W; i++) begin
			if (mx_s1[i]) begin
				msb = MSB_W'(i);
			end
		end
		sh = MSB_W'(NORM_BIT) - msb;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= XW'(x_s1) <<< sh;
			y_s[0]    <= XW'(y_s1) <<< sh;
			acc_s[0]  <= '0;
			base_s[0] <= base_s1;
			sp_s[0]   <= sp_s1;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_it
		logic signed [XW-1:0] dx, dy;
		logic                 pos;
		assign dx  = x_s[i] >>> i;
		assign dy  = y_s[i] >>> i;
		assign pos = !y_s[i][XW-1] && (y_s[i] != '0);
		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i+1]    <= pos ? x_s[i] + dy : x_s[i] - dy;
				y_s[i+1]    <= pos ? y_s[i] - dx : y_s[i] + dx;
				acc_s[i+1]  <= pos ? acc_s[i] + ATAN_TAB[i] : acc_s[i] - ATAN_TAB[i];
				base_s[i+1] <= base_s[i];
				sp_s[i+1]   <= sp_s[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle <= sp_s[CORDIC_STEPS] ? base_s[CORDIC_STEPS]
			                            : base_s[CORDIC_STEPS] + acc_s[CORDIC_STEPS];
		end
	end

endmodule

@@ hdl/quaternion_to_euler_angles_core.sv @@
// Converts one raw orientation quaternion per word into roll, pitch and negated
// yaw in degrees with ANGLE_FRAC_BITS fraction bits, plus a flag for a
// zero-length input (angles then zero). Latency from input accept to the output
// register is set by the 32-stage square root for pitch then the 23-stage
// arctangent pipelines. A word can enter every clock unless the pipeline holds,
// which it does while the output register and one-word skid buffer are full.
module quaternion_to_euler_angles_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // roll_angle, pitch_angle, yaw_angle, zero pad
	output logic        m_tuser    // degenerate
);
	import q2e_pkg::*;
	`include "quaternion_to_euler_angles_core_assert.svh"

	localparam int PIPE_LAT = 4 + SQRT_STEPS + CORDIC_LAT;
	localparam int DLY      = SQRT_STEPS + 1;

	logic adv;

	logic signed [15:0] qw, qx, qy, qz;

	logic [PIPE_LAT-1:0] vld_q;
	logic [PIPE_LAT-1:0] deg_q;

	prod_t ww_s1, xx_s1, yy_s1, zz_s1, xy_s1, wz_s1, xz_s1, wy_s1, yz_s1, wx_s1;

	mval_t len_c;
	mval_t len2_s2, m11_s2, m12_s2, m13_s2, m23_s2, m33_s2;

	mval_t lp_c, a_c, am_c;
	mval_t m11_s3, m12_s3, m23_s3, m33_s3, a_s3;
	logic [31:0] dif_s3;
	logic [32:0] sum_s3;

	logic [SQRT_W-1:0] d_s4;
	logic [SQRT_W/2-1:0] c_root;
	pend_t pend_s [0:DLY-1];

	angle_t roll_raw, pitch_raw, yaw_raw;
	wide_angle_t roll_c, pitch_c, yaw_c;
	logic new_vld, new_deg;

	logic               out_vld_q, skid_vld_q;
	logic signed [15:0] roll_q, yaw_q, skid_roll_q, skid_yaw_q;
	logic signed [14:0] pitch_q, skid_pitch_q;
	logic               deg_out_q, skid_deg_q;

	// The pipeline moves whenever the skid buffer is free.
	assign adv      = !skid_vld_q;
	assign s_tready = adv;

	assign qw = s_tdata[15:0];
	assign qx = s_tdata[31:16];
	assign qy = s_tdata[47:32];
	assign qz = s_tdata[63:48];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			deg_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], s_tvalid};
			deg_q <= {deg_q[PIPE_LAT-2:0], (s_tdata == '0)};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ww_s1 <= qw * qw;
			xx_s1 <= qx * qx;
			yy_s1 <= qy * qy;
			zz_s1 <= qz * qz;
			xy_s1 <= qx * qy;
			wz_s1 <= qw * qz;
			xz_s1 <= qx * qz;
			wy_s1 <= qw * qy;
			yz_s1 <= qy * qz;
			wx_s1 <= qw * qx;
		end
	end

	assign len_c = mval_t'(ww_s1) + mval_t'(xx_s1) + mval_t'(yy_s1) + mval_t'(zz_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			len2_s2 <= len_c;
			m11_s2  <= ((mval_t'(ww_s1) + mval_t'(xx_s1)) <<< 1) - len_c;
			m12_s2  <= (mval_t'(xy_s1) - mval_t'(wz_s1)) <<< 1;
			m13_s2  <= (mval_t'(xz_s1) + mval_t'(wy_s1)) <<< 1;
			m23_s2  <= (mval_t'(yz_s1) - mval_t'(wx_s1)) <<< 1;
			m33_s2  <= ((mval_t'(ww_s1) + mval_t'(zz_s1)) <<< 1) - len_c;
		end
	end

	// The asin argument: halve a large length, then clamp to one.
	always_comb begin
		if (len2_s2 > mval_t'(64'd2147483648)) begin
			lp_c = len2_s2 >>> 1;
			a_c  = m13_s2 >>> 1;
		end else begin
			lp_c = len2_s2;
			a_c  = m13_s2;
		end
		am_c = a_c[M_W-1] ? -a_c : a_c;
		if (am_c > lp_c) begin
			am_c = lp_c;
			a_c  = a_c[M_W-1] ? -lp_c : lp_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m11_s3 <= m11_s2;
			m12_s3 <= m12_s2;
			m23_s3 <= m23_s2;
			m33_s3 <= m33_s2;
			a_s3   <= a_c;
			dif_s3 <= 32'(lp_c - am_c);
			sum_s3 <= 33'(lp_c + am_c);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s4      <= SQRT_W'(dif_s3) * SQRT_W'(sum_s3);
			pend_s[0] <= '{m11: m11_s3, m12: m12_s3, m23: m23_s3, m33: m33_s3,
			               asin_num: a_s3};
			for (int k = 1; k < DLY; k++) begin
				pend_s[k] <= pend_s[k-1];
			end
		end
	end

	q2e_isqrt u_sqrt (
		.clk  (clk),
		.en   (adv),
		.rad  (d_s4),
		.root (c_root)
	);

	q2e_cordic u_roll (
		.clk   (clk),
		.en    (adv),
		.y_in  (pend_s[DLY-1].m23),
		.x_in  (pend_s[DLY-1].m33),
		.angle (roll_raw)
	);

	q2e_cordic u_yaw (
		.clk   (clk),
		.en    (adv),
		.y_in  (pend_s[DLY-1].m12),
		.x_in  (pend_s[DLY-1].m11),
		.angle (yaw_raw)
	);

	q2e_cordic u_pitch (
		.clk   (clk),
		.en    (adv),
		.y_in  (pend_s[DLY-1].asin_num),
		.x_in  (mval_t'(c_root)),
		.angle (pitch_raw)
	);

	assign roll_c  = to_out(wide_angle_t'(roll_raw), LIM180);
	assign pitch_c = to_out(wide_angle_t'(pitch_raw), LIM90);
	assign yaw_c   = to_out(-wide_angle_t'(yaw_raw), LIM180);
	assign new_vld = vld_q[PIPE_LAT-1];
	assign new_deg = deg_q[PIPE_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (adv) begin
			if (new_vld) begin
				if (!out_vld_q || m_tready) begin
					out_vld_q <= 1'b1;
				end else begin
					skid_vld_q <= 1'b1;
				end
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end else if (m_tready) begin
			skid_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (new_vld) begin
				if (!out_vld_q || m_tready) begin
					roll_q    <= new_deg ? '0 : 16'(roll_c);
					pitch_q   <= new_deg ? '0 : 15'(pitch_c);
					yaw_q     <= new_deg ? '0 : 16'(yaw_c);
					deg_out_q <= new_deg;
				end else begin
					skid_roll_q  <= new_deg ? '0 : 16'(roll_c);
					skid_pitch_q <= new_deg ? '0 : 15'(pitch_c);
					skid_yaw_q   <= new_deg ? '0 : 16'(yaw_c);
					skid_deg_q   <= new_deg;
				end
			end
		end else if (m_tready) begin
			roll_q    <= skid_roll_q;
			pitch_q   <= skid_pitch_q;
			yaw_q     <= skid_yaw_q;
			deg_out_q <= skid_deg_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, yaw_q, pitch_q, roll_q};
	assign m_tuser  = deg_out_q;

	`Q2E_ASSERT_NOW(a_skid_behind_out, skid_vld_q, out_vld_q, "skid word without output word")
	`Q2E_ASSERT_NEXT(a_skid_kept, skid_vld_q && !m_tready, skid_vld_q, "skid word dropped")
	`Q2E_ASSERT_NOW(a_deg_zero, out_vld_q && deg_out_q,
		roll_q == '0 && pitch_q == '0 && yaw_q == '0, "degenerate word has nonzero angle")
	`Q2E_ASSERT_NOW(a_pitch_range, out_vld_q,
		pitch_q <= 15'(LIM90) && pitch_q >= -15'(LIM90), "pitch beyond ninety degrees")

endmodule
